/* src/lsf_pkg.sv */
// Shared types and constants of the line substring filter.
package lsf_pkg;

	// Input opcodes carried on s_tuser
	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// Configuration register indexes
	localparam logic REG_INVERT     = 1'b0;
	localparam logic REG_COUNT_ONLY = 1'b1;

	// Characters with a meaning in the stream
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_NUL = 8'h00;

	// Saturation limit of the line and selection counters
	localparam logic [14:0] COUNT_MAX = 15'h7FFF;

	// Cells per registered AND group in the match reduction
	localparam int GROUP_SIZE = 16;

	// Result buffer geometry
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PTR_W = 4;
	localparam int FIFO_CNT_W = 5;

	// One result item
	typedef struct packed {
		logic        kind;
		logic [14:0] line_number;
		logic        hit;
		logic [14:0] match_total;
		logic        last;
	} res_t;

	// Shift controls shared by every cell of the row
	typedef struct packed {
		logic shift_window;
		logic double_shift;
		logic shift_needle;
	} cell_ctl_t;

	// Registered compare flags of one cell
	typedef struct packed {
		logic ok_a;
		logic ok_b;
	} cell_ok_t;

	// Event that travels down the match pipeline with each data or clear request
	typedef struct packed {
		logic valid;
		logic restart;
		logic check_a;
		logic check_b;
		logic end_line;
		logic end_data;
		logic empty;
	} event_t;

	// Write side of the result buffer: up to two results per cycle
	typedef struct packed {
		logic en0;
		logic en1;
		res_t d0;
		res_t d1;
	} fifo_wr_t;

endpackage

/* src/lsf_cell.sv */
// One cell of the row: a window byte, a needle byte and their compare flags.
module lsf_cell import lsf_pkg::*; #(
	parameter int INDEX = 0,
	parameter int LEN_W = 7
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [LEN_W-1:0] needle_len,
	input  logic [7:0]       win_in1,
	input  logic [7:0]       win_in2,
	input  logic [7:0]       win_up,
	input  logic [7:0]       needle_in,
	output logic [7:0]       win_out,
	output logic [7:0]       needle_out,
	output cell_ok_t         ok
);

	logic [7:0] win_q;
	logic [7:0] needle_q;
	logic       active;

	// This cell takes part when its position lies inside the needle
	assign active = needle_len > LEN_W'(INDEX);

	// Shift window and needle bytes along the row
	always_ff @(posedge clk) begin
		if (ctl.shift_window) begin
			win_q <= ctl.double_shift ? win_in2 : win_in1;
		end
		if (ctl.shift_needle) begin
			needle_q <= needle_in;
		end
	end

	// Compare at both alignments: window offset by one (first of two pushes) and in place
	always_ff @(posedge clk) begin
		ok.ok_a <= !active || (win_up == needle_q);
		ok.ok_b <= !active || (win_q == needle_q);
	end

	assign win_out    = win_q;
	assign needle_out = needle_q;

endmodule

/* src/lsf_result_fifo.sv */
// Result buffer that takes up to two results per cycle and hands out one.
module lsf_result_fifo import lsf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fifo_wr_t              wr,
	output res_t                  rd_data,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output logic [FIFO_CNT_W-1:0] level
);

	res_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [FIFO_CNT_W-1:0] push_n;
	logic                  pop;

	assign push_n = FIFO_CNT_W'(wr.en0) + FIFO_CNT_W'(wr.en1);
	assign pop    = rd_valid && rd_ready;

	// Store incoming results at the write pointer
	always_ff @(posedge clk) begin
		if (wr.en0) begin
			mem_q[wr_ptr_q] <= wr.d0;
		end
		if (wr.en1) begin
			mem_q[wr_ptr_q + FIFO_PTR_W'(1)] <= wr.d1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + push_n - FIFO_CNT_W'(pop);
		end
	end

	assign rd_data  = mem_q[rd_ptr_q];
	assign rd_valid = count_q != '0;
	assign level    = count_q;

endmodule

/* src/line_substring_filter.sv */
// Top level of the line substring filter: stream front end, cell row, match pipeline.
//
// Input stream: s_tuser carries the opcode (data byte, append needle byte, clear
// and restart), s_tdata the byte. A request is taken when s_tvalid and s_tready
// are high at a rising edge; the block takes one byte per cycle while s_tready is high.
// Each data byte shifts into a row of MAX_NEEDLE cells that compare the recent
// line bytes with the needle in parallel; a CR that must be flushed ahead of the
// next byte shifts the row by two at once. The compare flags pass through a
// registered AND tree; the event of the request that ends the line passes the
// stages s1, s2 and s3 before its result is placed in the result buffer, from
// where it is offered on the output stream.
// Output stream: m_tuser is the result kind, m_tlast marks the last result
// of one request. The result buffer holds 16 results; s_tready falls when the
// buffer plus the requests still in the pipeline could fill it, so a stalled
// receiver stops the input side after a few requests and nothing is lost.
// Configuration: wr_en with wr_index 0 (invert) or 1 (count only), written
// while the stream is idle.
// Reset clears the needle length, all line and stream state and both registers.
module line_substring_filter import lsf_pkg::*; #(
	parameter int MAX_NEEDLE     = 127,
	parameter int MAX_FILE_BYTES = 16383
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [14:0] line_number, [15] hit, [30:16] match_total, [31] zero
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic        wr_data
);

	localparam int LEN_W  = $clog2(MAX_NEEDLE + 1);
	localparam int BC_W   = $clog2(MAX_FILE_BYTES + 1);
	localparam int NGRP   = (MAX_NEEDLE + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int NEED_W = FIFO_CNT_W + 1;

	// Configuration registers
	logic invert_q;
	logic count_only_q;

	// Front-end state
	logic [LEN_W-1:0] needle_len_q;
	logic [LEN_W-1:0] fill_q;
	logic             pcr_q;
	logic [BC_W-1:0]  byte_cnt_q;
	logic             finished_q;
	logic [7:0]       tail_q;

	// Pipeline and final stage state
	event_t           ev_s1;
	event_t           ev_s2;
	event_t           ev_s3;
	logic [NGRP-1:0]  grp_a_s3;
	logic [NGRP-1:0]  grp_b_s3;
	logic             lhm_q;
	logic [14:0]      line_cnt_q;
	logic [14:0]      sel_cnt_q;

	// Front-end next values
	logic             accept;
	logic             at_limit;
	logic [7:0]       data_b;
	logic [LEN_W-1:0] fill1;
	logic [LEN_W-1:0] fill2;
	logic             needle_nz;
	cell_ctl_t        ctl;
	event_t           ev_n;
	logic [LEN_W-1:0] needle_len_n;
	logic [LEN_W-1:0] fill_n;
	logic             pcr_n;
	logic [BC_W-1:0]  byte_cnt_n;
	logic             finished_n;

	// Row wiring
	logic [7:0] win_all    [MAX_NEEDLE + 1];
	logic [7:0] win_in1    [MAX_NEEDLE + 1];
	logic [7:0] win_in2    [MAX_NEEDLE + 1];
	logic [7:0] needle_all [MAX_NEEDLE];
	logic [7:0] needle_in  [MAX_NEEDLE];
	cell_ok_t   ok_all     [MAX_NEEDLE];

	// Reduction and final stage signals
	logic [NGRP-1:0] grp_a_n;
	logic [NGRP-1:0] grp_b_n;
	logic            match_now;
	logic            line_sel;
	logic [14:0]     line_cnt_n;
	logic [14:0]     sel_cnt_n;
	res_t            res_line;
	res_t            res_end;
	fifo_wr_t        fifo_wr;
	res_t            res_out;
	logic [FIFO_CNT_W-1:0] fifo_level;
	logic [2:0]      inflight;
	logic [NEED_W-1:0] need;

	assign accept    = s_tvalid && s_tready;
	assign at_limit  = byte_cnt_q == BC_W'(MAX_FILE_BYTES);
	assign data_b    = at_limit ? CHAR_NUL : s_tdata;
	assign fill1     = (fill_q == LEN_W'(MAX_NEEDLE)) ? fill_q : fill_q + LEN_W'(1);
	assign fill2     = (fill1 == LEN_W'(MAX_NEEDLE)) ? fill1 : fill1 + LEN_W'(1);
	assign needle_nz = needle_len_q != '0;

	// Decode the request: row shifts, line bookkeeping and the pipeline event
	always_comb begin
		ctl          = '0;
		ev_n         = '0;
		needle_len_n = needle_len_q;
		fill_n       = fill_q;
		pcr_n        = pcr_q;
		byte_cnt_n   = byte_cnt_q;
		finished_n   = finished_q;
		case (s_tuser)
			OP_APPEND: begin
				if (s_tdata != CHAR_NUL && needle_len_q != LEN_W'(MAX_NEEDLE)) begin
					ctl.shift_needle = 1'b1;
					needle_len_n     = needle_len_q + LEN_W'(1);
				end
			end
			OP_CLEAR: begin
				needle_len_n = '0;
				fill_n       = '0;
				pcr_n        = 1'b0;
				byte_cnt_n   = '0;
				finished_n   = 1'b0;
				ev_n.valid   = 1'b1;
				ev_n.restart = 1'b1;
			end
			OP_DATA: begin
				if (!finished_q) begin
					ev_n.valid = 1'b1;
					if (!at_limit) begin
						byte_cnt_n = byte_cnt_q + BC_W'(1);
					end
					if (data_b != CHAR_NUL && data_b != CHAR_LF) begin
						if (pcr_q && data_b == CHAR_CR) begin
							// held CR enters, the new CR is held in its place
							ctl.shift_window = 1'b1;
							fill_n           = fill1;
							ev_n.check_b     = needle_nz && fill1 >= needle_len_q;
						end else if (pcr_q) begin
							// held CR and this byte enter together
							ctl.shift_window = 1'b1;
							ctl.double_shift = 1'b1;
							fill_n           = fill2;
							pcr_n            = 1'b0;
							ev_n.check_a     = needle_nz && fill1 >= needle_len_q;
							ev_n.check_b     = needle_nz && fill2 >= needle_len_q;
						end else if (data_b == CHAR_CR) begin
							pcr_n = 1'b1;
						end else begin
							ctl.shift_window = 1'b1;
							fill_n           = fill1;
							ev_n.check_b     = needle_nz && fill1 >= needle_len_q;
						end
					end else begin
						// line ends here; a held CR is dropped
						ev_n.end_line = 1'b1;
						ev_n.end_data = data_b == CHAR_NUL;
						ev_n.empty    = !needle_nz;
						fill_n        = '0;
						pcr_n         = 1'b0;
						finished_n    = data_b == CHAR_NUL;
					end
				end
			end
			default: begin
			end
		endcase
		if (!accept) begin
			ctl  = '0;
			ev_n = '0;
		end
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q     <= 1'b0;
			count_only_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_INVERT:     invert_q     <= wr_data;
				REG_COUNT_ONLY: count_only_q <= wr_data;
				default: begin
				end
			endcase
		end
	end

	// Update front-end state on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_len_q <= '0;
			fill_q       <= '0;
			pcr_q        <= 1'b0;
			byte_cnt_q   <= '0;
			finished_q   <= 1'b0;
		end else if (accept) begin
			needle_len_q <= needle_len_n;
			fill_q       <= fill_n;
			pcr_q        <= pcr_n;
			byte_cnt_q   <= byte_cnt_n;
			finished_q   <= finished_n;
		end
	end

	// Feed the row: first cell takes the new byte, second cell the flushed CR
	genvar j;
	generate
		for (j = 0; j <= MAX_NEEDLE; j++) begin : g_feed
			if (j == 0) begin : g_first
				assign win_in1[j] = data_b;
				assign win_in2[j] = data_b;
			end else if (j == 1) begin : g_second
				assign win_in1[j] = win_all[j-1];
				assign win_in2[j] = CHAR_CR;
			end else begin : g_rest
				assign win_in1[j] = win_all[j-1];
				assign win_in2[j] = win_all[j-2];
			end
		end
	endgenerate

	// Extra byte past the last cell for the offset compare
	always_ff @(posedge clk) begin
		if (ctl.shift_window) begin
			tail_q <= ctl.double_shift ? win_in2[MAX_NEEDLE] : win_in1[MAX_NEEDLE];
		end
	end
	assign win_all[MAX_NEEDLE] = tail_q;

	// Row of compare cells
	genvar k;
	generate
		for (k = 0; k < MAX_NEEDLE; k++) begin : g_cell
			if (k == 0) begin : g_head
				assign needle_in[k] = s_tdata;
			end else begin : g_body
				assign needle_in[k] = needle_all[k-1];
			end
			lsf_cell #(
				.INDEX (k),
				.LEN_W (LEN_W)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.needle_len (needle_len_q),
				.win_in1    (win_in1[k]),
				.win_in2    (win_in2[k]),
				.win_up     (win_all[k+1]),
				.needle_in  (needle_in[k]),
				.win_out    (win_all[k]),
				.needle_out (needle_all[k]),
				.ok         (ok_all[k])
			);
		end
	endgenerate

	// AND the cell flags in groups
	always_comb begin
		grp_a_n = '1;
		grp_b_n = '1;
		for (int i = 0; i < MAX_NEEDLE; i++) begin
			grp_a_n[i / GROUP_SIZE] = grp_a_n[i / GROUP_SIZE] & ok_all[i].ok_a;
			grp_b_n[i / GROUP_SIZE] = grp_b_n[i / GROUP_SIZE] & ok_all[i].ok_b;
		end
	end

	// Advance the event pipeline alongside the compare stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1 <= '0;
			ev_s2 <= '0;
			ev_s3 <= '0;
		end else begin
			ev_s1 <= ev_n;
			ev_s2 <= ev_s1;
			ev_s3 <= ev_s2;
		end
	end

	always_ff @(posedge clk) begin
		grp_a_s3 <= grp_a_n;
		grp_b_s3 <= grp_b_n;
	end

	// Resolve the line decision and build results
	always_comb begin
		match_now  = (ev_s3.check_a && (&grp_a_s3)) || (ev_s3.check_b && (&grp_b_s3));
		line_sel   = (lhm_q || ev_s3.empty) ^ invert_q;
		line_cnt_n = (line_cnt_q != COUNT_MAX) ? line_cnt_q + 15'd1 : line_cnt_q;
		sel_cnt_n  = (line_sel && sel_cnt_q != COUNT_MAX) ? sel_cnt_q + 15'd1 : sel_cnt_q;

		res_line.kind        = 1'b0;
		res_line.line_number = line_cnt_n;
		res_line.hit         = line_sel;
		res_line.match_total = sel_cnt_n;
		res_line.last        = !ev_s3.end_data;

		res_end.kind         = 1'b1;
		res_end.line_number  = line_cnt_n;
		res_end.hit          = 1'b0;
		res_end.match_total  = sel_cnt_n;
		res_end.last         = 1'b1;

		fifo_wr = '0;
		if (ev_s3.valid && ev_s3.end_line) begin
			if (count_only_q) begin
				fifo_wr.en0 = ev_s3.end_data;
				fifo_wr.d0  = res_end;
			end else begin
				fifo_wr.en0 = 1'b1;
				fifo_wr.d0  = res_line;
				fifo_wr.en1 = ev_s3.end_data;
				fifo_wr.d1  = res_end;
			end
		end
	end

	// Accumulate the line match and the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lhm_q      <= 1'b0;
			line_cnt_q <= '0;
			sel_cnt_q  <= '0;
		end else if (ev_s3.valid) begin
			if (ev_s3.restart) begin
				lhm_q      <= 1'b0;
				line_cnt_q <= '0;
				sel_cnt_q  <= '0;
			end else if (ev_s3.end_line) begin
				lhm_q      <= 1'b0;
				line_cnt_q <= line_cnt_n;
				sel_cnt_q  <= sel_cnt_n;
			end else if (match_now) begin
				lhm_q <= 1'b1;
			end
		end
	end

	lsf_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (fifo_wr),
		.rd_data  (res_out),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.level    (fifo_level)
	);

	// Take a request only while two result slots remain for it after those in flight
	assign inflight = 3'(ev_s1.valid) + 3'(ev_s2.valid) + 3'(ev_s3.valid);
	assign need     = NEED_W'(fifo_level) + NEED_W'({inflight, 1'b0}) + NEED_W'(2);
	assign s_tready = need <= NEED_W'(FIFO_DEPTH);

	assign m_tdata = {1'b0, res_out.match_total, res_out.hit, res_out.line_number};
	assign m_tuser = res_out.kind;
	assign m_tlast = res_out.last;

endmodule

/* bench/line_substring_filter_checker.sv */
// Result checker for the line substring filter: tracks requests, predicts results, compares.
module line_substring_filter_checker import lsf_pkg::*; #(
	parameter int MAX_NEEDLE     = 127,
	parameter int MAX_FILE_BYTES = 16383
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [14:0] line_number, [15] hit, [30:16] match_total, [31] zero
	input  logic        m_tuser,   // [0] kind
	input  logic        m_tlast,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic        wr_data,
	output int          fail_count,
	output int          results_seen,
	output int          results_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_LINE  = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	// Register copies
	logic flag_invert;
	logic flag_count_only;

	// Needle and line state
	logic [7:0]  needle_bytes [MAX_NEEDLE];
	int          needle_len;
	logic [7:0]  recent_bytes [MAX_NEEDLE];   // newest first
	int          recent_fill;
	bit          line_found;
	bit          cr_held;
	logic [14:0] lines_done;
	logic [14:0] lines_selected;
	int          bytes_taken;
	bit          stream_ended;

	res_t expected_q[$];
	int   mismatches;
	int   accepted_results;

	function automatic void clear_line();
		for (int k = 0; k < MAX_NEEDLE; k++)
			recent_bytes[k] = 8'h00;
		recent_fill = 0;
		line_found  = 1'b0;
		cr_held     = 1'b0;
	endfunction

	function automatic void clear_stream();
		clear_line();
		lines_done     = '0;
		lines_selected = '0;
		bytes_taken    = 0;
		stream_ended   = 1'b0;
	endfunction

	// Shift one byte into the line window and compare its tail with the needle
	function automatic void shift_line_byte(logic [7:0] b);
		bit same;
		for (int k = MAX_NEEDLE - 1; k > 0; k--)
			recent_bytes[k] = recent_bytes[k - 1];
		recent_bytes[0] = b;
		if (recent_fill < MAX_NEEDLE)
			recent_fill++;
		if (needle_len == 0 || recent_fill < needle_len)
			return;
		same = 1'b1;
		for (int k = 0; k < needle_len; k++)
			if (recent_bytes[k] !== needle_bytes[needle_len - 1 - k])
				same = 1'b0;
		if (same)
			line_found = 1'b1;
	endfunction

	// Work out the results of one accepted request
	function automatic void predict_request(logic [1:0] op, logic [7:0] b);
		logic hit;
		res_t r;
		int   before_cnt;
		case (op)
			OP_APPEND: begin
				if (b != CHAR_NUL && needle_len < MAX_NEEDLE) begin
					needle_bytes[needle_len] = b;
					needle_len++;
				end
			end
			OP_CLEAR: begin
				needle_len = 0;
				clear_stream();
			end
			OP_DATA: begin
				if (stream_ended)
					return;
				// past the size limit any byte ends the data
				if (bytes_taken >= MAX_FILE_BYTES)
					b = CHAR_NUL;
				else
					bytes_taken++;
				if (b != CHAR_NUL && b != CHAR_LF) begin
					if (cr_held) begin
						cr_held = 1'b0;
						shift_line_byte(CHAR_CR);
					end
					if (b == CHAR_CR)
						cr_held = 1'b1;
					else
						shift_line_byte(b);
					return;
				end
				// line ends here; a held CR is dropped
				hit = line_found || needle_len == 0;
				if (flag_invert)
					hit = !hit;
				if (lines_done != COUNT_MAX)
					lines_done++;
				if (hit && lines_selected != COUNT_MAX)
					lines_selected++;
				before_cnt = expected_q.size();
				if (!flag_count_only) begin
					r.kind        = KIND_LINE;
					r.line_number = lines_done;
					r.hit         = hit;
					r.match_total = lines_selected;
					r.last        = 1'b0;
					expected_q.push_back(r);
				end
				clear_line();
				if (b == CHAR_NUL) begin
					stream_ended  = 1'b1;
					r.kind        = KIND_TOTAL;
					r.line_number = lines_done;
					r.hit         = 1'b0;
					r.match_total = lines_selected;
					r.last        = 1'b0;
					expected_q.push_back(r);
				end
				if (expected_q.size() > before_cnt)
					expected_q[expected_q.size() - 1].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	// Print one line per mismatch and count it
	task automatic report_mismatch(string msg);
		mismatches++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	// Compare one accepted result with the oldest expectation
	task automatic check_result();
		res_t want;
		accepted_results++;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("result with nothing expected (kind %0d, line %0d)",
				m_tuser, m_tdata[14:0]));
			return;
		end
		want = expected_q.pop_front();
		if (m_tuser !== want.kind)
			report_mismatch($sformatf("kind: expected %0d, got %0d", want.kind, m_tuser));
		if (m_tdata[14:0] !== want.line_number)
			report_mismatch($sformatf("line_number: expected %0d, got %0d",
				want.line_number, m_tdata[14:0]));
		if (m_tdata[15] !== want.hit)
			report_mismatch($sformatf("hit on line %0d: expected %0d, got %0d",
				want.line_number, want.hit, m_tdata[15]));
		if (m_tdata[30:16] !== want.match_total)
			report_mismatch($sformatf("match_total: expected %0d, got %0d",
				want.match_total, m_tdata[30:16]));
		if (m_tdata[31] !== 1'b0)
			report_mismatch("padding bit of result data not zero");
		if (m_tlast !== want.last)
			report_mismatch($sformatf("last on line %0d: expected %0d, got %0d",
				want.line_number, want.last, m_tlast));
	endtask

	// Follow register writes, requests and results at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_invert     = 1'b0;
			flag_count_only = 1'b0;
			needle_len      = 0;
			clear_stream();
			expected_q.delete();
			results_waiting <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_INVERT:     flag_invert = wr_data;
					REG_COUNT_ONLY: flag_count_only = wr_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_request(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				check_result();
			results_waiting <= expected_q.size();
			fail_count      <= mismatches;
			results_seen    <= accepted_results;
		end
	end

endmodule

/* bench/line_substring_filter_tb.sv */
// Testbench top for the line substring filter: clock, reset, stimulus, receiver and verdict.
module line_substring_filter_tb import lsf_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         MAX_NEEDLE     = 127;
	localparam int         MAX_FILE_BYTES = 16383;
	localparam int         IDLE_LIMIT     = 4000;
	localparam int         SETTLE_CYCLES  = 12;
	localparam int         PHASE_ITEMS    = 30;
	localparam logic [1:0] OP_UNUSED      = 2'd3;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic [1:0]  s_tuser  = OP_DATA;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        wr_en    = 1'b0;
	logic        wr_index = REG_INVERT;
	logic        wr_data  = 1'b0;

	int fail_count;
	int results_seen;
	int results_waiting;

	int sent_total    = 0;
	int counted_items = 0;
	bit stream_done   = 1'b0;
	bit steady        = 1'b0;

	line_substring_filter #(
		.MAX_NEEDLE     (MAX_NEEDLE),
		.MAX_FILE_BYTES (MAX_FILE_BYTES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	line_substring_filter_checker #(
		.MAX_NEEDLE     (MAX_NEEDLE),
		.MAX_FILE_BYTES (MAX_FILE_BYTES)
	) u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.fail_count      (fail_count),
		.results_seen    (results_seen),
		.results_waiting (results_waiting)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Gap length: mostly none, often short, now and then long
	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] needle_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return 8'h61 + 8'($urandom_range(0, 2));
		if (r < 95)
			return 8'($urandom_range(0, 255));
		if (r < 97)
			return CHAR_CR;
		if (r < 99)
			return 8'hFF;
		return CHAR_NUL;
	endfunction

	function automatic logic [7:0] line_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 8'h61 + 8'($urandom_range(0, 2));
		if (r < 78)
			return CHAR_CR;
		if (r < 95)
			return 8'($urandom_range(1, 255));
		if (r < 99)
			return 8'hFF;
		return CHAR_NUL;
	endfunction

	// Offer one request, hold it until taken, then maybe leave a gap
	task automatic send(logic [1:0] op, logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_total++;
		if (op != OP_UNUSED && !(op == OP_DATA && stream_done))
			counted_items++;
		if (op == OP_CLEAR)
			stream_done = 1'b0;
		else if (op == OP_DATA && b == CHAR_NUL)
			stream_done = 1'b1;
		if (sent_total % 64 == 0)
			steady = ($urandom_range(0, 3) == 0);
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every expected result, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic inv, logic cnt_only);
		wr_en    <= 1'b1;
		wr_index <= REG_INVERT;
		wr_data  <= inv;
		@(posedge clk);
		wr_index <= REG_COUNT_ONLY;
		wr_data  <= cnt_only;
		@(posedge clk);
		wr_en    <= 1'b0;
	endtask

	// Extremes, every opcode, CR handling, end of data and needle edits
	task automatic directed_run();
		send(OP_DATA, 8'h78);
		send(OP_DATA, CHAR_LF);            // empty needle selects the line
		send(OP_APPEND, CHAR_NUL);         // zero needle byte is dropped
		send(OP_APPEND, 8'h61);
		send(OP_APPEND, 8'hFF);
		send(OP_DATA, 8'h61);
		send(OP_DATA, 8'hFF);
		send(OP_DATA, CHAR_CR);
		send(OP_DATA, CHAR_LF);            // CR before LF is not part of the line
		send(OP_DATA, 8'h61);
		send(OP_DATA, CHAR_CR);
		send(OP_DATA, 8'hFF);
		send(OP_DATA, CHAR_LF);            // held CR enters the line, breaks the match
		send(OP_DATA, 8'h61);
		send(OP_DATA, 8'hFF);
		send(OP_APPEND, 8'h63);            // needle grows mid-line, found match stays
		send(OP_DATA, CHAR_LF);
		send(OP_UNUSED, 8'hFF);
		send(OP_DATA, CHAR_CR);
		send(OP_DATA, CHAR_NUL);           // last line plus total
		send(OP_DATA, 8'h41);              // ignored after end of data
		send(OP_APPEND, 8'h41);            // still taken after end of data
		send(OP_CLEAR, 8'hFF);
		send(OP_DATA, CHAR_NUL);           // empty data: one empty line
		send(OP_CLEAR, CHAR_NUL);
	endtask

	// One well-formed stretch: optional restart and needle, a few lines, maybe an end
	task automatic run_episode();
		int n_lines;
		int len;
		int r;
		if (stream_done || $urandom_range(0, 7) == 0) begin
			send(OP_CLEAR, 8'($urandom));
			repeat ($urandom_range(0, 4)) send(OP_APPEND, needle_byte());
		end else if ($urandom_range(0, 3) == 0) begin
			send(OP_APPEND, needle_byte());
		end
		n_lines = $urandom_range(1, 4);
		for (int l = 0; l < n_lines; l++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					send(OP_APPEND, needle_byte());
				else if (r < 7)
					send(OP_UNUSED, 8'($urandom));
				else
					send(OP_DATA, line_byte());
			end
			if ($urandom_range(0, 4) == 0)
				send(OP_DATA, CHAR_CR);
			if (l == n_lines - 1 && $urandom_range(0, 1) == 0)
				send(OP_DATA, CHAR_NUL);
			else
				send(OP_DATA, CHAR_LF);
		end
		if (stream_done && $urandom_range(0, 4) == 0) begin
			send(OP_DATA, line_byte());
			send(OP_APPEND, needle_byte());
		end
	endtask

	task automatic random_phase();
		int items_at_start;
		items_at_start = counted_items;
		while (counted_items - items_at_start < PHASE_ITEMS)
			run_episode();
	endtask

	// Needle filled to capacity with surplus appends, then a line that hits it and one that misses
	task automatic full_needle_run();
		logic [7:0] pattern [MAX_NEEDLE + 3];
		send(OP_CLEAR, CHAR_NUL);
		for (int i = 0; i < MAX_NEEDLE + 3; i++) begin
			pattern[i] = 8'($urandom_range(8'h20, 8'h7E));
			send(OP_APPEND, pattern[i]);
		end
		repeat (3) send(OP_DATA, 8'h10);
		for (int i = 0; i < MAX_NEEDLE; i++)
			send(OP_DATA, pattern[i]);
		send(OP_DATA, CHAR_LF);
		for (int i = 1; i < MAX_NEEDLE; i++)
			send(OP_DATA, pattern[i]);
		send(OP_DATA, CHAR_CR);
		send(OP_DATA, CHAR_NUL);
	endtask

	// Receiver: runs of ready, broken by gaps, with some long runs
	initial begin
		int run;
		int gap;
		forever begin
			run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 6) : $urandom_range(40, 150);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = pause_len();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run after too many cycles with no transfer at all
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Main sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(1'b0, 1'b0);
		directed_run();
		settle();

		write_regs(1'b1, 1'b0);
		random_phase();
		settle();
		write_regs(1'b0, 1'b1);
		random_phase();
		settle();
		write_regs(1'b1, 1'b1);
		random_phase();
		settle();
		write_regs(1'b0, 1'b0);
		random_phase();
		full_needle_run();
		settle();

		$display("Run covered %0d requests and %0d results under all four register settings,",
			sent_total, results_seen);
		$display("including a full-length needle with surplus appends.");
		if (fail_count == 0 && results_waiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
src/lsf_pkg.sv
src/lsf_cell.sv
src/lsf_result_fifo.sv
src/line_substring_filter.sv
bench/line_substring_filter_checker.sv
bench/line_substring_filter_tb.sv
